// ----- hw/rtl/bilinear_table_interpolator_core_assert.svh -----
// assertion macros shared by the interpolator rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef BILINEAR_TABLE_INTERPOLATOR_CORE_ASSERT_SVH
`define BILINEAR_TABLE_INTERPOLATOR_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BTI_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that holds on every clock edge outside reset
`define BTI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ----- hw/rtl/bti_pkg.sv -----
// shared types, constants and helpers of the bilinear table interpolator
// no dependencies
package bti_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_BITS  = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_ORIGIN       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_INV_STEP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DENSITY_INV_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DENSITY_POINTS_USED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_POINTS_USED  = 3'd4;

	// register reset values
	localparam logic [31:0] ENERGY_ORIGIN_RST       = 32'd0;
	localparam logic [31:0] ENERGY_INV_STEP_RST     = 32'd3273523;
	localparam logic [31:0] DENSITY_INV_STEP_RST    = 32'd3254955;
	localparam logic [8:0]  DENSITY_POINTS_USED_RST = 9'd150;
	localparam logic [10:0] ENERGY_POINTS_USED_RST  = 11'd1000;

	localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

	// clip a 42 bit signed sum to the signed 32 bit range
	function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
		if (v > 42'sd2147483647) begin
			return INT32_MAX;
		end else if (v < -42'sd2147483648) begin
			return INT32_MIN;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

// ----- hw/rtl/bti_bank.sv -----
// one bank of table storage: single port ram with registered read data
// uses bti_pkg for the entry width
module bti_bank #(
	parameter int DEPTH = 2,
	parameter int AW    = 1
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               addr,
	input  logic [bti_pkg::DATA_W-1:0]  wdata,
	output logic [bti_pkg::DATA_W-1:0]  rdata
);
	import bti_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/bti_locate.sv -----
// grid locator for one axis: magnitude, scale by reciprocal step, cell and fraction
// three register stages, uses bti_pkg constants
module bti_locate #(
	parameter int CW = 8
) (
	input  logic                clk,
	input  logic signed [32:0]  diff,
	input  logic [31:0]         inv_step,
	input  logic [CW-1:0]       last_cell,
	output logic [CW-1:0]       cell_idx,
	output logic signed [31:0]  frac
);
	import bti_pkg::*;

	logic              neg_s2;
	logic [32:0]       mag_s2;
	logic              neg_s3;
	logic [47:0]       scaled_s3;
	logic [CW-1:0]     cell_s4;
	logic signed [31:0] frac_s4;

	logic [64:0]       prod;
	logic [23:0]       cell_full;
	logic [47:0]       over;
	logic [CW-1:0]     cell_n;
	logic signed [31:0] frac_n;

	always_ff @(posedge clk) begin
		neg_s2 <= diff[32];
		mag_s2 <= diff[32] ? 33'(-diff) : 33'(diff);
	end

	// product < 2^64, drop 16 bits to land in q.24
	assign prod = 65'(mag_s2) * 65'(inv_step);

	always_ff @(posedge clk) begin
		neg_s3    <= neg_s2;
		scaled_s3 <= prod[63:16];
	end

	assign cell_full = scaled_s3[47:FRAC_BITS];
	assign over      = scaled_s3 - (48'(last_cell) << FRAC_BITS);

	always_comb begin
		if (neg_s3) begin
			cell_n = '0;
			if (scaled_s3 > 48'h0000_8000_0000) begin
				frac_n = INT32_MIN;
			end else begin
				frac_n = -$signed(scaled_s3[31:0]);
			end
		end else if (cell_full > 24'(last_cell)) begin
			// beyond the last cell: extrapolate, clip far values
			cell_n = last_cell;
			frac_n = (over[47:31] != '0) ? INT32_MAX : $signed(over[31:0]);
		end else begin
			cell_n = cell_full[CW-1:0];
			frac_n = $signed({8'd0, scaled_s3[FRAC_BITS-1:0]});
		end
	end

	always_ff @(posedge clk) begin
		cell_s4 <= cell_n;
		frac_s4 <= frac_n;
	end

	assign cell_idx = cell_s4;
	assign frac     = frac_s4;

endmodule

// ----- hw/rtl/bti_lerp.sv -----
// linear blend a + floor((b - a) * f / 2^24) with signed 32 bit saturation
// three register stages, uses bti_pkg::sat32
module bti_lerp (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic signed [31:0] f,
	output logic signed [31:0] y
);
	import bti_pkg::*;

	logic signed [31:0] a_s1;
	logic signed [32:0] d_s1;
	logic signed [31:0] f_s1;
	logic signed [31:0] a_s2;
	logic signed [64:0] p_s2;
	logic signed [31:0] y_s3;

	logic signed [64:0] prod;
	logic signed [41:0] sum;

	always_ff @(posedge clk) begin
		a_s1 <= a;
		d_s1 <= 33'(b) - 33'(a);
		f_s1 <= f;
	end

	assign prod = 65'(d_s1) * 65'(f_s1);

	always_ff @(posedge clk) begin
		a_s2 <= a_s1;
		p_s2 <= prod;
	end

	// arithmetic shift of the product is the floor division
	assign sum = 42'(a_s2) + 42'($signed(p_s2[64:FRAC_BITS]));

	always_ff @(posedge clk) begin
		y_s3 <= sat32(sum);
	end

	assign y = y_s3;

endmodule

// ----- hw/rtl/bilinear_table_interpolator_core.sv -----
// Bilinear table interpolator, top level: config registers, pipeline control, four table banks.
// Takes one item every clock; busy stays low. A query result reaches result_valid through the register
// stages intake 1, locate 3, bank read 2, blends 3+3, output 1.
// Table writes land in the bank stage and give no result.
// arst_n clears config registers to defaults and empties the pipeline; table contents are
// undefined until written. Depends on bti_pkg, bti_locate, bti_bank, bti_lerp and the assert header.
module bilinear_table_interpolator_core #(
	parameter int NUM_TABLES      = 7,
	parameter int DENSITY_POINTS  = 256,
	parameter int ENERGY_POINTS   = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cmd,
	input  logic [2:0]                        table_select,
	input  logic [7:0]                        row_index,
	input  logic [9:0]                        column_index,
	input  logic signed [31:0]                entry_value,
	input  logic signed [31:0]                energy_coord,
	input  logic signed [31:0]                density_coord,
	output logic                              result_valid,
	output logic [30:0]                       interp_value,
	input  logic                              cfg_we,
	input  logic [bti_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bti_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import bti_pkg::*;

	`include "bilinear_table_interpolator_core_assert.svh"

	localparam int DCW        = $clog2(DENSITY_POINTS);
	localparam int ECW        = $clog2(ENERGY_POINTS);
	localparam int DH         = (DENSITY_POINTS + 1) / 2;
	localparam int EH         = (ENERGY_POINTS + 1) / 2;
	localparam int BANK_DEPTH = NUM_TABLES * DH * EH;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	typedef struct packed {
		logic        tok;
		logic [2:0]  tsel;
		logic [7:0]  row;
		logic [9:0]  col;
		logic [31:0] wval;
	} item_t;

	function automatic int last_cell(input int used, input int maxp);
		if (used < 2) begin
			return 0;
		end else if (used > maxp) begin
			return maxp - 2;
		end else begin
			return used - 2;
		end
	endfunction

	function automatic logic [BANK_AW-1:0] bank_addr(input int t, input int rh, input int ch);
		return BANK_AW'((t * DH + rh) * EH + ch);
	endfunction

	// configuration registers
	logic [31:0] energy_origin_q;
	logic [31:0] energy_inv_step_q;
	logic [31:0] density_inv_step_q;
	logic [8:0]  density_points_used_q;
	logic [10:0] energy_points_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_origin_q       <= ENERGY_ORIGIN_RST;
			energy_inv_step_q     <= ENERGY_INV_STEP_RST;
			density_inv_step_q    <= DENSITY_INV_STEP_RST;
			density_points_used_q <= DENSITY_POINTS_USED_RST;
			energy_points_used_q  <= ENERGY_POINTS_USED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENERGY_ORIGIN:       energy_origin_q       <= cfg_wdata;
				REG_ENERGY_INV_STEP:     energy_inv_step_q     <= cfg_wdata;
				REG_DENSITY_INV_STEP:    density_inv_step_q    <= cfg_wdata;
				REG_DENSITY_POINTS_USED: density_points_used_q <= cfg_wdata[8:0];
				REG_ENERGY_POINTS_USED:  energy_points_used_q  <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	logic [DCW-1:0] d_last;
	logic [ECW-1:0] e_last;

	assign d_last = DCW'(last_cell(int'(density_points_used_q), DENSITY_POINTS));
	assign e_last = ECW'(last_cell(int'(energy_points_used_q), ENERGY_POINTS));

	// intake
	logic        accept;
	logic        tsel_bad;
	logic signed [32:0] ediff;
	logic signed [32:0] dabs;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign tsel_bad = int'(table_select) >= NUM_TABLES;
	assign ediff    = 33'(energy_coord) - 33'($signed(energy_origin_q));
	assign dabs     = density_coord[31] ? -33'(density_coord) : 33'(density_coord);

	// control pipeline
	logic qv_s1, qv_s2, qv_s3, qv_s4, qv_s5, qv_s6, qv_s7;
	logic qv_s8, qv_s9, qv_s10, qv_s11, qv_s12, qv_s13;
	logic wv_s1, wv_s2, wv_s3, wv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s1  <= 1'b0;
			qv_s2  <= 1'b0;
			qv_s3  <= 1'b0;
			qv_s4  <= 1'b0;
			qv_s5  <= 1'b0;
			qv_s6  <= 1'b0;
			qv_s7  <= 1'b0;
			qv_s8  <= 1'b0;
			qv_s9  <= 1'b0;
			qv_s10 <= 1'b0;
			qv_s11 <= 1'b0;
			qv_s12 <= 1'b0;
			qv_s13 <= 1'b0;
			wv_s1  <= 1'b0;
			wv_s2  <= 1'b0;
			wv_s3  <= 1'b0;
			wv_s4  <= 1'b0;
		end else begin
			qv_s1  <= accept && (cmd == CMD_QUERY);
			wv_s1  <= accept && (cmd == CMD_WRITE);
			qv_s2  <= qv_s1;
			qv_s3  <= qv_s2;
			qv_s4  <= qv_s3;
			qv_s5  <= qv_s4;
			qv_s6  <= qv_s5;
			qv_s7  <= qv_s6;
			qv_s8  <= qv_s7;
			qv_s9  <= qv_s8;
			qv_s10 <= qv_s9;
			qv_s11 <= qv_s10;
			qv_s12 <= qv_s11;
			qv_s13 <= qv_s12;
			wv_s2  <= wv_s1;
			wv_s3  <= wv_s2;
			wv_s4  <= wv_s3;
		end
	end

	// payload up to the locators' output
	item_t item_s1, item_s2, item_s3, item_s4;
	logic signed [32:0] ediff_s1;
	logic signed [32:0] dabs_s1;

	always_ff @(posedge clk) begin
		item_s1.tok  <= !tsel_bad;
		item_s1.tsel <= table_select;
		item_s1.row  <= row_index;
		item_s1.col  <= column_index;
		item_s1.wval <= entry_value;
		ediff_s1     <= ediff;
		dabs_s1      <= dabs;
		item_s2      <= item_s1;
		item_s3      <= item_s2;
		item_s4      <= item_s3;
	end

	logic [DCW-1:0]     cell_d_s4;
	logic [ECW-1:0]     cell_e_s4;
	logic signed [31:0] fx_s4;
	logic signed [31:0] fy_s4;

	bti_locate #(.CW(DCW)) u_locate_d (
		.clk       (clk),
		.diff      (dabs_s1),
		.inv_step  (density_inv_step_q),
		.last_cell (d_last),
		.cell_idx  (cell_d_s4),
		.frac      (fx_s4)
	);

	bti_locate #(.CW(ECW)) u_locate_e (
		.clk       (clk),
		.diff      (ediff_s1),
		.inv_step  (energy_inv_step_q),
		.last_cell (e_last),
		.cell_idx  (cell_e_s4),
		.frac      (fy_s4)
	);

	// bank stage: banks split by row and column parity so the four corners read at once
	logic                wr_ok;
	logic [3:0]          we_n;
	logic [BANK_AW-1:0]  addr_n [4];
	int                  rh_even, rh_odd, ch_even, ch_odd;

	assign wr_ok = wv_s4 && item_s4.tok
		&& (int'(item_s4.row) < DENSITY_POINTS) && (int'(item_s4.col) < ENERGY_POINTS);

	assign rh_odd  = int'(cell_d_s4) >> 1;
	assign rh_even = (int'(cell_d_s4) >> 1) + int'(cell_d_s4[0]);
	assign ch_odd  = int'(cell_e_s4) >> 1;
	assign ch_even = (int'(cell_e_s4) >> 1) + int'(cell_e_s4[0]);

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			we_n[b] = wr_ok && (item_s4.row[0] == b[1]) && (item_s4.col[0] == b[0]);
			if (wv_s4) begin
				addr_n[b] = bank_addr(int'(item_s4.tsel), int'(item_s4.row) >> 1,
					int'(item_s4.col) >> 1);
			end else begin
				addr_n[b] = bank_addr(int'(item_s4.tsel), b[1] ? rh_odd : rh_even,
					b[0] ? ch_odd : ch_even);
			end
		end
	end

	logic [3:0]          bank_we_s5;
	logic [BANK_AW-1:0]  bank_addr_s5 [4];
	logic [31:0]         wval_s5;
	logic                tok_s5, iodd_s5, jodd_s5;
	logic signed [31:0]  fx_s5, fy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_we_s5 <= '0;
		end else begin
			bank_we_s5 <= we_n;
		end
	end

	always_ff @(posedge clk) begin
		bank_addr_s5 <= addr_n;
		wval_s5      <= item_s4.wval;
		tok_s5       <= item_s4.tok;
		iodd_s5      <= cell_d_s4[0];
		jodd_s5      <= cell_e_s4[0];
		fx_s5        <= fx_s4;
		fy_s5        <= fy_s4;
	end

	logic [31:0] bank_rd_s6 [4];

	for (genvar g = 0; g < 4; g++) begin : g_bank
		bti_bank #(.DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_bank (
			.clk   (clk),
			.we    (bank_we_s5[g]),
			.addr  (bank_addr_s5[g]),
			.wdata (wval_s5),
			.rdata (bank_rd_s6[g])
		);
	end

	logic               tok_s6, iodd_s6, jodd_s6;
	logic signed [31:0] fx_s6, fy_s6, fx_s7, fx_s8, fx_s9;
	logic               tok_s7, tok_s8, tok_s9, tok_s10, tok_s11, tok_s12;

	always_ff @(posedge clk) begin
		tok_s6  <= tok_s5;
		iodd_s6 <= iodd_s5;
		jodd_s6 <= jodd_s5;
		fx_s6   <= fx_s5;
		fy_s6   <= fy_s5;
		fx_s7   <= fx_s6;
		fx_s8   <= fx_s7;
		fx_s9   <= fx_s8;
		tok_s7  <= tok_s6;
		tok_s8  <= tok_s7;
		tok_s9  <= tok_s8;
		tok_s10 <= tok_s9;
		tok_s11 <= tok_s10;
		tok_s12 <= tok_s11;
	end

	// corners by parity of the cell
	logic signed [31:0] c00, c01, c10, c11;

	assign c00 = bank_rd_s6[{iodd_s6, jodd_s6}];
	assign c01 = bank_rd_s6[{iodd_s6, !jodd_s6}];
	assign c10 = bank_rd_s6[{!iodd_s6, jodd_s6}];
	assign c11 = bank_rd_s6[{!iodd_s6, !jodd_s6}];

	logic signed [31:0] r0_s9, r1_s9, v_s12;

	bti_lerp u_lerp_r0 (.clk(clk), .a(c00), .b(c01), .f(fy_s6), .y(r0_s9));
	bti_lerp u_lerp_r1 (.clk(clk), .a(c10), .b(c11), .f(fy_s6), .y(r1_s9));
	bti_lerp u_lerp_v  (.clk(clk), .a(r0_s9), .b(r1_s9), .f(fx_s9), .y(v_s12));

	// clamp at zero, bad table reads as zero
	logic [30:0] value_s13;

	always_ff @(posedge clk) begin
		value_s13 <= (!tok_s12 || v_s12[31]) ? '0 : v_s12[30:0];
	end

	assign result_valid = qv_s13;
	assign interp_value = value_s13;

	`BTI_ASSERT_IMPL(a_result_from_query, result_valid,
		$past(accept && (cmd == CMD_QUERY), 13), "result without a query item")
	`BTI_ASSERT_IMPL(a_bad_table_zero, result_valid && $past(tsel_bad, 13),
		interp_value == '0, "bad table query gave nonzero value")
	`BTI_ASSERT_ALWAYS(a_one_bank_write, $onehot0(bank_we_s5), "more than one bank written")
	`BTI_ASSERT_ALWAYS(a_no_write_on_query, !(qv_s5 && (bank_we_s5 != '0)),
		"bank write during a query item")

endmodule

// ----- sim/bilinear_table_interpolator_core_test.sv -----
// testbench for bilinear_table_interpolator_core: drives writes and lookups through start/busy
// and checks every interp_value against a local fixed-point predictor; needs bti_pkg and the rtl
module bilinear_table_interpolator_core_test;

	localparam int NUM_TABLES     = 7;
	localparam int DENSITY_POINTS = 256;
	localparam int ENERGY_POINTS  = 1024;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct {
		bit               cmd;
		bit [2:0]         tsel;
		bit [7:0]         row;
		bit [9:0]         col;
		bit signed [31:0] entry;
		bit signed [31:0] ecoord;
		bit signed [31:0] dcoord;
	} lookup_item_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic                            cmd;
	logic [2:0]                      table_select;
	logic [7:0]                      row_index;
	logic [9:0]                      column_index;
	logic signed [31:0]              entry_value;
	logic signed [31:0]              energy_coord;
	logic signed [31:0]              density_coord;
	logic                            result_valid;
	logic [30:0]                     interp_value;
	logic                            cfg_we;
	logic [bti_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [bti_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	// shadow of the table contents and of the register file
	bit signed [31:0] entry_mem [int];
	bit signed [31:0] origin_q = bti_pkg::ENERGY_ORIGIN_RST;
	bit [31:0]        einv_q   = bti_pkg::ENERGY_INV_STEP_RST;
	bit [31:0]        dinv_q   = bti_pkg::DENSITY_INV_STEP_RST;
	bit [8:0]         dpts_q   = bti_pkg::DENSITY_POINTS_USED_RST;
	bit [10:0]        epts_q   = bti_pkg::ENERGY_POINTS_USED_RST;

	bit [30:0] pending_interp [$];
	bit [30:0] want_interp;
	int        mismatches = 0;
	int        items_sent = 0;
	int        idle_pct = 0;

	bilinear_table_interpolator_core #(
		.NUM_TABLES    (NUM_TABLES),
		.DENSITY_POINTS(DENSITY_POINTS),
		.ENERGY_POINTS (ENERGY_POINTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.table_select (table_select),
		.row_index    (row_index),
		.column_index (column_index),
		.entry_value  (entry_value),
		.energy_coord (energy_coord),
		.density_coord(density_coord),
		.result_valid (result_valid),
		.interp_value (interp_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic int clamp_pts(input int raw, input int hi);
		if (raw < 2) begin
			return 2;
		end
		if (raw > hi) begin
			return hi;
		end
		return raw;
	endfunction

	function automatic int flat_index(input int t, input int r, input int c);
		return (t * DENSITY_POINTS + r) * ENERGY_POINTS + c;
	endfunction

	// grid cell below a scaled offset, plus the q.24 fraction past it (not limited to one cell, clipped to 32 bits)
	function automatic void find_cell(input longint diff, input bit [31:0] inv, input int points,
			output int lower, output longint frac);
		bit [63:0] mag, s, c;
		longint    f;
		mag = (diff < 0) ? 64'(-diff) : 64'(diff);
		s = (mag * {32'd0, inv}) >> 16;
		if (diff < 0) begin
			lower = 0;
			f = -longint'(s);
		end else begin
			c = s >> 24;
			if (c > 64'(points - 2)) begin
				c = 64'(points - 2);
			end
			lower = int'(c);
			f = longint'(s) - longint'(c << 24);
		end
		frac = clip32(f);
	endfunction

	function automatic void grid_position(input lookup_item_t it, output int di,
			output longint dfrac, output int ej, output longint efrac);
		longint d, e;
		d = longint'(it.dcoord);
		if (d < 0) begin
			d = -d;
		end
		e = longint'(it.ecoord) - longint'(origin_q);
		find_cell(d, dinv_q, clamp_pts(dpts_q, DENSITY_POINTS), di, dfrac);
		find_cell(e, einv_q, clamp_pts(epts_q, ENERGY_POINTS), ej, efrac);
	endfunction

	function automatic longint stored_entry(input int t, input int r, input int c);
		return longint'(entry_mem[flat_index(t, r, c)]);
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint f);
		return clip32(a + (((b - a) * f) >>> 24));
	endfunction

	function automatic bit [30:0] predict_interp(input lookup_item_t it);
		int     di, ej, t;
		longint dfrac, efrac, r0, r1, v;
		if (it.tsel >= NUM_TABLES) begin
			return '0;
		end
		t = int'(it.tsel);
		grid_position(it, di, dfrac, ej, efrac);
		r0 = blend(stored_entry(t, di, ej), stored_entry(t, di, ej + 1), efrac);
		r1 = blend(stored_entry(t, di + 1, ej), stored_entry(t, di + 1, ej + 1), efrac);
		v = blend(r0, r1, dfrac);
		if (v < 0) begin
			v = 0;
		end
		return v[30:0];
	endfunction

	// ---------------- result checking ----------------

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1) begin
			if (pending_interp.size() == 0) begin
				$error("interp_value: expected none, actual %0d", interp_value);
				mismatches++;
			end else begin
				want_interp = pending_interp.pop_front();
				if (interp_value !== want_interp) begin
					$error("interp_value: expected %0d, actual %0d", want_interp, interp_value);
					mismatches++;
				end
			end
		end
	end

	// ---------------- drivers ----------------

	function automatic lookup_item_t make_item(input bit c, input bit [2:0] t, input bit [7:0] r,
			input bit [9:0] col, input bit [31:0] v, input bit [31:0] e, input bit [31:0] d);
		lookup_item_t it;
		it.cmd = c;
		it.tsel = t;
		it.row = r;
		it.col = col;
		it.entry = v;
		it.ecoord = e;
		it.dcoord = d;
		return it;
	endfunction

	task automatic send_item(input lookup_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		cmd           <= it.cmd;
		table_select  <= it.tsel;
		row_index     <= it.row;
		column_index  <= it.col;
		entry_value   <= it.entry;
		energy_coord  <= it.ecoord;
		density_coord <= it.dcoord;
		do @(posedge clk); while (busy !== 1'b0);
		items_sent++;
		if (it.cmd == bti_pkg::CMD_WRITE) begin
			if (it.tsel < NUM_TABLES) begin
				entry_mem[flat_index(it.tsel, it.row, it.col)] = it.entry;
			end
		end else begin
			pending_interp.push_back(predict_interp(it));
		end
	endtask

	task automatic put_entry(input bit [2:0] t, input bit [7:0] r, input bit [9:0] c,
			input bit [31:0] v);
		send_item(make_item(bti_pkg::CMD_WRITE, t, r, c, v, $urandom, $urandom));
	endtask

	// loads any corner of the target cell that was never written, then issues the lookup
	task automatic run_query(input bit [2:0] t, input bit [31:0] e, input bit [31:0] d);
		lookup_item_t it;
		int           di, ej;
		longint       dfrac, efrac;
		it = make_item(bti_pkg::CMD_QUERY, t, 8'($urandom_range(255)),
			10'($urandom_range(1023)), $urandom, e, d);
		if (t < NUM_TABLES) begin
			grid_position(it, di, dfrac, ej, efrac);
			for (int dr = 0; dr < 2; dr++) begin
				for (int dc = 0; dc < 2; dc++) begin
					if (!entry_mem.exists(flat_index(t, di + dr, ej + dc))) begin
						put_entry(t, 8'(di + dr), 10'(ej + dc), $urandom);
					end
				end
			end
		end
		send_item(it);
	endtask

	task automatic drain_pipeline();
		start <= 1'b0;
		while (pending_interp.size() != 0) begin
			@(posedge clk);
		end
		// trailing table writes give no result, so let them land too
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [bti_pkg::CFG_IDX_W-1:0] idx, input bit [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic apply_settings(input bit signed [31:0] org, input bit [31:0] einv,
			input bit [31:0] dinv, input bit [8:0] dp, input bit [10:0] ep);
		cfg_put(bti_pkg::REG_ENERGY_ORIGIN, org);
		cfg_put(bti_pkg::REG_ENERGY_INV_STEP, einv);
		cfg_put(bti_pkg::REG_DENSITY_INV_STEP, dinv);
		cfg_put(bti_pkg::REG_DENSITY_POINTS_USED, {23'd0, dp});
		cfg_put(bti_pkg::REG_ENERGY_POINTS_USED, {21'd0, ep});
		cfg_we <= 1'b0;
		origin_q = org;
		einv_q = einv;
		dinv_q = dinv;
		dpts_q = dp;
		epts_q = ep;
	endtask

	// ---------------- random stimulus helpers ----------------

	// mostly lands within or just around the grid in use, sometimes anywhere
	function automatic bit signed [31:0] pick_coord(input bit signed [31:0] base,
			input bit [31:0] inv, input int points);
		longint span, v;
		if (inv == 0 || $urandom_range(3) == 0) begin
			return $urandom;
		end
		span = (longint'(points) << 40) / longint'({32'd0, inv});
		if (span > 64'sd2147483648) begin
			span = 64'sd2147483648;
		end
		if (span < 64) begin
			span = 64;
		end
		v = longint'(base) + longint'($urandom_range(0, 32'(span + span / 4))) - span / 16;
		return 32'(clip32(v));
	endfunction

	function automatic bit signed [31:0] rand_origin();
		bit signed [31:0] org;
		org = $urandom_range(0, 32'h0800_0000);
		return org - 32'sh0400_0000;
	endfunction

	function automatic bit [31:0] rand_inv();
		return $urandom_range(32'h0004_0000, 32'h0080_0000);
	endfunction

	task automatic random_item();
		bit [2:0]         t;
		bit signed [31:0] e, d;
		if ($urandom_range(99) < 15) begin
			put_entry(3'($urandom_range(7)), 8'($urandom_range(255)),
				10'($urandom_range(1023)), $urandom);
		end else begin
			t = ($urandom_range(15) == 0) ? 3'd7 : 3'($urandom_range(NUM_TABLES - 1));
			e = pick_coord(origin_q, einv_q, clamp_pts(epts_q, ENERGY_POINTS));
			d = pick_coord(32'sd0, dinv_q, clamp_pts(dpts_q, DENSITY_POINTS));
			if ($urandom_range(1) == 1) begin
				d = -d;
			end
			run_query(t, e, d);
		end
	endtask

	task automatic run_phase(input int pct, input bit signed [31:0] org, input bit [31:0] einv,
			input bit [31:0] dinv, input bit [8:0] dp, input bit [10:0] ep, input int n);
		int stop_at;
		drain_pipeline();
		apply_settings(org, einv, dinv, dp, ep);
		idle_pct = pct;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			random_item();
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_reset_config();
		run_query(3'd0, 32'sd0, 32'sd0);
		run_query(3'd3, bti_pkg::INT32_MAX, bti_pkg::INT32_MIN);
		// nonexistent table: write dropped, lookup reads zero
		put_entry(3'd7, 8'd5, 10'd5, 32'h1234_5678);
		run_query(3'd7, $urandom, $urandom);
	endtask

	task automatic test_blend_limits();
		longint ew, dw;
		ew = (64'sd1 <<< 40) / longint'({32'd0, einv_q});
		dw = (64'sd1 <<< 40) / longint'({32'd0, dinv_q});
		put_entry(3'd2, 8'd0, 10'd0, bti_pkg::INT32_MIN);
		put_entry(3'd2, 8'd0, 10'd1, bti_pkg::INT32_MAX);
		put_entry(3'd2, 8'd1, 10'd0, bti_pkg::INT32_MAX);
		put_entry(3'd2, 8'd1, 10'd1, bti_pkg::INT32_MAX);
		run_query(3'd2, 32'(ew * 3 / 4), 32'sd0);
		run_query(3'd2, 32'(ew / 2), 32'sd0);
		// far below the grid: fraction saturates, blend goes negative and clamps to zero
		run_query(3'd2, bti_pkg::INT32_MIN, 32'sd0);
		run_query(3'd2, 32'(ew / 3), 32'(-(dw / 2)));
	endtask

	task automatic test_register_limits();
		drain_pipeline();
		// points below two act as two; far positive extrapolation saturates upward
		apply_settings(bti_pkg::INT32_MIN, 32'hFFFF_FFFF, 32'd0, 9'd0, 11'd1);
		run_query(3'd2, bti_pkg::INT32_MAX, 32'sd0);
		run_query(3'd5, $urandom, $urandom);
		drain_pipeline();
		// points above the table size act as the table size
		apply_settings(bti_pkg::INT32_MAX, 32'd0, 32'hFFFF_FFFF, 9'd511, 11'd2047);
		run_query(3'd6, bti_pkg::INT32_MIN, bti_pkg::INT32_MAX);
		drain_pipeline();
		apply_settings(32'sd0, 32'h0100_0000, 32'h0100_0000, 9'd256, 11'd1024);
		run_query(3'd4, bti_pkg::INT32_MAX, bti_pkg::INT32_MAX);
	endtask

	task automatic test_random_traffic();
		run_phase(0, rand_origin(), rand_inv(), rand_inv(), 9'd150, 11'd1000, 92);
		run_phase(70, $urandom, $urandom, $urandom, 9'd1, 11'd0, 92);
		run_phase(7, rand_origin(), 32'd0, 32'hFFFF_FFFF, 9'd511, 11'd2047, 92);
		run_phase(70, rand_origin(), rand_inv(), rand_inv(), 9'($urandom_range(511)),
			11'($urandom_range(2047)), 92);
		run_phase(0, rand_origin(), rand_inv(), rand_inv(), 9'd256, 11'd1024, 92);
		run_phase(7, rand_origin(), rand_inv(), rand_inv(), 9'($urandom_range(2, 40)),
			11'($urandom_range(2, 60)), 92);
	endtask

	initial begin
		arst_n        <= 1'b0;
		start         <= 1'b0;
		cmd           <= bti_pkg::CMD_WRITE;
		table_select  <= '0;
		row_index     <= '0;
		column_index  <= '0;
		entry_value   <= '0;
		energy_coord  <= '0;
		density_coord <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= bti_pkg::REG_ENERGY_ORIGIN;
		cfg_wdata     <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_blend_limits();
		test_register_limits();
		test_random_traffic();
		drain_pipeline();
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bti_pkg.sv
hw/rtl/bti_bank.sv
hw/rtl/bti_locate.sv
hw/rtl/bti_lerp.sv
hw/rtl/bilinear_table_interpolator_core.sv
sim/bilinear_table_interpolator_core_test.sv
